// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the blur block.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/bb_pkg.sv
// Shared types and constants of the box blur block.
// Used by the front end, the job queue, the back end and the top level.
package bb_pkg;

  localparam int DIM_W = 11;
  localparam int SLOT_W = 4;
  localparam int SPAN_W = 4;
  localparam int CNT_W = 8;
  localparam int SUM_W = 16;
  localparam int PIX_W = 24;
  localparam int QDEPTH = 2;
  localparam int QP_W = $clog2(QDEPTH);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [DIM_W-1:0] dim_t;

  // One pending output: the window to sum and where it sits in the frame.
  typedef struct packed {
    logic [SLOT_W-1:0] slot0;
    logic [SPAN_W-1:0] nrows;
    dim_t              c0;
    logic [SPAN_W-1:0] ncols;
    dim_t              row;
    logic              parity;
    logic              last;
  } job_t;

  typedef struct packed {
    logic  busy;
    dim_t  row;
    logic  parity;
  } back_status_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    job_t  head;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_DRAIN,
    BK_LOAD,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// File: rtl/bb_if.sv
// Stream interfaces for the pixel input and the result output.
// Payload widths follow the field widths; no package is needed.
interface bb_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, kind, in_red, in_green, in_blue, input ready);
  modport sink (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface bb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// File: rtl/bb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module bb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bb_queue.sv
// Short job queue between the front end and the back end.
// Depends on bb_pkg for the job type and depth.
module bb_queue import bb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output queue_status_t q_st
);

  job_t            entries [QDEPTH];
  logic [QP_W-1:0] wptr;
  logic [QP_W-1:0] rptr;
  logic [QP_W:0]   count;

  assign q_st.empty = (count == '0);
  assign q_st.full = (count == (QP_W+1)'(QDEPTH));
  assign q_st.head = entries[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QP_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QP_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bb_front.sv
// Front end: accepts items, tracks frame positions, writes the line memory
// and queues one job per ready output. Depends on bb_pkg and bb_if.
module bb_front import bb_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WINDOW = 9,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              rst,
  bb_pix_if.sink            in_ch,
  input  dim_t              img_w,
  input  dim_t              img_h,
  input  back_status_t      back_st,
  input  queue_status_t     q_st,
  output logic              push,
  output job_t              push_job,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [PIX_W-1:0]  ram_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = ADDR_W - CW;
  localparam int E = DIM_W + 1;
  localparam int HALF = WINDOW / 2;
  localparam int SLOTS = WINDOW + 1;
  localparam logic [E-1:0] HALF_X = E'(HALF);
  localparam logic [E-1:0] SLOTS_X = E'(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [12:0] MAXW_X = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH_X = 13'(MAX_HEIGHT);

  typedef logic [E-1:0] ext_t;

  dim_t              fw, fh, irow, icol, orow, ocol;
  logic [SLOT_W-1:0] islot, oslot;
  logic              done, parity;

  dim_t              fw_next, fh_next, irow_next, icol_next, orow_next, ocol_next;
  logic [SLOT_W-1:0] islot_next, oslot_next;
  logic              done_next, parity_next;

  logic              do_write, hazard, out_ready, accept;
  dim_t              irow_adv, icol_adv;
  logic [SLOT_W-1:0] islot_adv;
  logic              done_adv;
  ext_t              need_r, need_c, r0, c0, old_row;
  logic [SPAN_W-1:0] above, left;
  logic [SLOT_W:0]   slot_sum;
  logic              old_par, last;

  // A zero size reads as one, an oversized one saturates.
  function automatic dim_t clamp_dim(dim_t v, logic [12:0] maxv);
    if (v == '0) begin
      return dim_t'(1);
    end
    if ({2'b00, v} > maxv) begin
      return maxv[DIM_W-1:0];
    end
    return v;
  endfunction

  // Input side: frame sizes and the position after this item's pixel.
  always_comb begin
    do_write = (in_ch.kind == KIND_PIXEL) && !done;
    fw_next = fw;
    fh_next = fh;
    if (do_write && irow == '0 && icol == '0) begin
      fw_next = clamp_dim(img_w, MAXW_X);
      fh_next = clamp_dim(img_h, MAXH_X);
    end
    irow_adv = irow;
    icol_adv = icol;
    islot_adv = islot;
    done_adv = done;
    if (do_write) begin
      if ({1'b0, icol} + 1'b1 >= {1'b0, fw_next}) begin
        icol_adv = '0;
        if ({1'b0, irow} + 1'b1 >= {1'b0, fh_next}) begin
          irow_adv = '0;
          islot_adv = '0;
          done_adv = 1'b1;
        end else begin
          irow_adv = irow + 1'b1;
          islot_adv = (islot == SLOT_LAST) ? '0 : islot + 1'b1;
        end
      end else begin
        icol_adv = icol + 1'b1;
      end
    end
  end

  // Readiness of the next output and the window it covers.
  always_comb begin
    need_r = {1'b0, orow} + HALF_X;
    if (need_r > {1'b0, fh_next} - 1'b1) begin
      need_r = {1'b0, fh_next} - 1'b1;
    end
    need_c = {1'b0, ocol} + HALF_X;
    if (need_c > {1'b0, fw_next} - 1'b1) begin
      need_c = {1'b0, fw_next} - 1'b1;
    end
    out_ready = done_adv || ({1'b0, irow_adv} > need_r) ||
                ({1'b0, irow_adv} == need_r && {1'b0, icol_adv} > need_c);
    above = ({1'b0, orow} >= HALF_X) ? SPAN_W'(HALF) : SPAN_W'(orow);
    left = ({1'b0, ocol} >= HALF_X) ? SPAN_W'(HALF) : SPAN_W'(ocol);
    r0 = {1'b0, orow} - ext_t'(above);
    c0 = {1'b0, ocol} - ext_t'(left);
    if ({1'b0, oslot} >= {1'b0, above}) begin
      slot_sum = {1'b0, oslot} - {1'b0, above};
    end else begin
      slot_sum = {1'b0, oslot} + (SLOT_W+1)'(SLOTS) - {1'b0, above};
    end
    last = ({1'b0, ocol} + 1'b1 >= {1'b0, fw_next}) &&
           ({1'b0, orow} + 1'b1 >= {1'b0, fh_next});
    push_job.slot0 = slot_sum[SLOT_W-1:0];
    push_job.nrows = SPAN_W'(need_r - r0 + 1'b1);
    push_job.c0 = c0[DIM_W-1:0];
    push_job.ncols = SPAN_W'(need_c - c0 + 1'b1);
    push_job.row = orow;
    push_job.parity = parity;
    push_job.last = last;
  end

  // A write may not overwrite a line-memory row that a pending job still reads.
  always_comb begin
    old_row = back_st.busy ? {1'b0, back_st.row} : {1'b0, q_st.head.row};
    old_par = back_st.busy ? back_st.parity : q_st.head.parity;
    hazard = (back_st.busy || !q_st.empty) &&
             ((old_par != parity) || ({1'b0, irow} + HALF_X >= old_row + SLOTS_X));
  end

  assign in_ch.ready = !q_st.full && !(do_write && hazard);
  assign accept = in_ch.valid && in_ch.ready;
  assign push = accept && out_ready;

  assign ram_we = accept && do_write;
  assign ram_waddr = {islot[SW-1:0], CW'(icol)};
  assign ram_wdata = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  // Output side advance; the frame's last output restarts the input side.
  always_comb begin
    irow_next = irow_adv;
    icol_next = icol_adv;
    islot_next = islot_adv;
    done_next = done_adv;
    orow_next = orow;
    ocol_next = ocol;
    oslot_next = oslot;
    parity_next = parity;
    if (out_ready) begin
      if (last) begin
        irow_next = '0;
        icol_next = '0;
        islot_next = '0;
        done_next = 1'b0;
        orow_next = '0;
        ocol_next = '0;
        oslot_next = '0;
        parity_next = !parity;
      end else if ({1'b0, ocol} + 1'b1 >= {1'b0, fw_next}) begin
        ocol_next = '0;
        orow_next = orow + 1'b1;
        oslot_next = (oslot == SLOT_LAST) ? '0 : oslot + 1'b1;
      end else begin
        ocol_next = ocol + 1'b1;
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= dim_t'(1);
      fh <= dim_t'(1);
      irow <= '0;
      icol <= '0;
      islot <= '0;
      done <= 1'b0;
      orow <= '0;
      ocol <= '0;
      oslot <= '0;
      parity <= 1'b0;
    end else if (accept) begin
      fw <= fw_next;
      fh <= fh_next;
      irow <= irow_next;
      icol <= icol_next;
      islot <= islot_next;
      done <= done_next;
      orow <= orow_next;
      ocol <= ocol_next;
      oslot <= oslot_next;
      parity <= parity_next;
    end
  end

endmodule

// File: rtl/bb_back.sv
// Back end: sums each job's window from the line memory, one pixel a cycle,
// divides by the pixel count bit-serially and holds the result item.
// Depends on bb_pkg and bb_if.
module bb_back import bb_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int WINDOW = 9,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     q_st,
  output logic              pop,
  output back_status_t      back_st,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [PIX_W-1:0]  ram_rdata,
  bb_res_if.source          out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = ADDR_W - CW;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW);
  localparam logic [3:0] STEP_LAST = 4'(SUM_W - 1);

  back_state_t       state, state_next;
  job_t              job;
  logic [SPAN_W-1:0] ri, ci;
  logic [SLOT_W-1:0] slot;
  logic              rd_valid, last_read;
  logic [3:0]        step;
  logic [CNT_W-1:0]  den;
  logic [SUM_W-1:0]  acc [3];
  logic [SUM_W-1:0]  dq [3];
  logic [CNT_W-1:0]  rem [3];
  logic [SUM_W-1:0]  dq_next [3];
  logic [CNT_W-1:0]  rem_next [3];
  logic [CNT_W:0]    trial [3];
  logic [CNT_W:0]    diff [3];
  dim_t              col;

  assign last_read = (ri == job.nrows - 1'b1) && (ci == job.ncols - 1'b1);
  assign col = job.c0 + dim_t'(ci);
  assign ram_raddr = {slot[SW-1:0], CW'(col)};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_st.empty) begin
          state_next = BK_SUM;
        end
      end
      BK_SUM: begin
        if (last_read) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: state_next = BK_LOAD;
      BK_LOAD: state_next = BK_DIV;
      BK_DIV: begin
        if (step == STEP_LAST) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ch.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop = (state == BK_IDLE) && !q_st.empty;
    ram_re = (state == BK_SUM);
    out_ch.valid = (state == BK_OUT);
    back_st.busy = (state != BK_IDLE);
    back_st.row = job.row;
    back_st.parity = job.parity;
  end

  // One restoring division step per channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = {rem[ch], dq[ch][SUM_W-1]};
      diff[ch] = trial[ch] - {1'b0, den};
      if (trial[ch] >= {1'b0, den}) begin
        rem_next[ch] = diff[ch][CNT_W-1:0];
        dq_next[ch] = {dq[ch][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[ch] = trial[ch][CNT_W-1:0];
        dq_next[ch] = {dq[ch][SUM_W-2:0], 1'b0};
      end
    end
  end

  assign out_ch.out_red = dq[0][7:0];
  assign out_ch.out_green = dq[1][7:0];
  assign out_ch.out_blue = dq[2][7:0];
  assign out_ch.frame_end = job.last;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid <= ram_re;
    end
  end

  // Datapath: window walk, accumulation and division.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!q_st.empty) begin
          job <= q_st.head;
          ri <= '0;
          ci <= '0;
          slot <= q_st.head.slot0;
          for (int ch = 0; ch < 3; ch++) begin
            acc[ch] <= '0;
          end
        end
      end
      BK_SUM: begin
        if (ci == job.ncols - 1'b1) begin
          ci <= '0;
          ri <= ri + 1'b1;
          slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
        end else begin
          ci <= ci + 1'b1;
        end
      end
      BK_LOAD: begin
        den <= CNT_W'(job.nrows) * CNT_W'(job.ncols);
        step <= '0;
        for (int ch = 0; ch < 3; ch++) begin
          dq[ch] <= acc[ch];
          rem[ch] <= '0;
        end
      end
      BK_DIV: begin
        step <= step + 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          dq[ch] <= dq_next[ch];
          rem[ch] <= rem_next[ch];
        end
      end
      default: begin
      end
    endcase
    // The read issued last cycle lands now.
    if (rd_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc[ch] + SUM_W'(ram_rdata[PIX_W-1-8*ch -: 8]);
      end
    end
  end

endmodule

// File: rtl/box_blur_streaming_top.sv
// Edge-clipped box blur: an item that readies an output gives it once the back end has
// summed the window's nrows*ncols pixels through the single line-memory read port and
// run the 16-step divider. The front stops taking items once two jobs wait in the queue,
// or when a pixel would overwrite a line that a pending job still reads.
// Reset clears all control state at once; the line memory is not cleared.
module box_blur_streaming_top import bb_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WINDOW = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bb_pix_if.sink      in_ch,
  bb_res_if.source    out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(WINDOW + 1);
  localparam int ADDR_W = SW + CW;

  dim_t              img_w, img_h;
  back_status_t      back_st;
  queue_status_t     q_st;
  logic              push, pop;
  job_t              push_job;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= dim_t'(1024);
      img_h <= dim_t'(1024);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WIDTH: img_w <= pwdata[DIM_W-1:0];
        REG_HEIGHT: img_h <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'((paddr[2] == REG_HEIGHT) ? img_h : img_w);

  bb_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WINDOW(WINDOW),
    .ADDR_W(ADDR_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .img_w(img_w),
    .img_h(img_h),
    .back_st(back_st),
    .q_st(q_st),
    .push(push),
    .push_job(push_job),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  bb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .q_st(q_st)
  );

  bb_ram #(
    .WIDTH(PIX_W),
    .DEPTH((WINDOW + 1) << CW)
  ) u_line_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bb_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .WINDOW(WINDOW),
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_st(q_st),
    .pop(pop),
    .back_st(back_st),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_ch(out_ch)
  );

endmodule

// File: rtl/bb_checker.sv
// Port-level checks of the blur block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bb_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready
);

  // A waiting result item is not withdrawn.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // The register port never inserts wait states.
  `ASSERT_NOW(a_pready, clk, rst, 1'b1, pready)

  // The width register reads back what was just written to it.
  `ASSERT_NEXT(a_width_readback, clk, rst, psel && penable && pwrite && !paddr[2], paddr[2] || prdata == {21'b0, $past(pwdata[10:0])})

  // No result item is shown right after reset.
  `ASSERT_NOW(a_reset_quiet, clk, rst, $past(rst), !out_valid)

endmodule

bind box_blur_streaming_top bb_checker u_bb_checker (
  .clk(clk),
  .rst(rst),
  .psel(psel),
  .penable(penable),
  .pwrite(pwrite),
  .paddr(paddr),
  .pwdata(pwdata),
  .prdata(prdata),
  .pready(pready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready)
);
